>>> hdl/sbcl_pkg.sv
// Package for the swept box collision limit block.
// Holds the default widths and the normal codes; depends on nothing.
package sbcl_pkg;
  localparam int CoordBits = 16;
  localparam int FracBits  = 16;

  localparam logic signed [1:0] NormNone = 2'sb00;
  localparam logic signed [1:0] NormPos  = 2'sb01;
  localparam logic signed [1:0] NormNeg  = 2'sb11;
endpackage

>>> hdl/sbcl_if.sv
// Valid/ready channel interfaces for the swept box collision limit block.
// Depends on sbcl_pkg for the default widths.
interface sbcl_in_if #(
  parameter int CB = sbcl_pkg::CoordBits,
  parameter int FB = sbcl_pkg::FracBits
);
  logic valid;
  logic ready;
  logic signed [CB-1:0] a_x;
  logic signed [CB-1:0] a_y;
  logic [CB-2:0] a_width;
  logic [CB-2:0] a_height;
  logic signed [CB-1:0] b_x;
  logic signed [CB-1:0] b_y;
  logic [CB-2:0] b_width;
  logic [CB-2:0] b_height;
  logic signed [CB-1:0] move_x;
  logic signed [CB-1:0] move_y;
  logic [FB:0] limit_in_x;
  logic [FB:0] limit_in_y;
  modport source (output valid, a_x, a_y, a_width, a_height, b_x, b_y, b_width,
                  b_height, move_x, move_y, limit_in_x, limit_in_y, input ready);
  modport sink (input valid, a_x, a_y, a_width, a_height, b_x, b_y, b_width,
                b_height, move_x, move_y, limit_in_x, limit_in_y, output ready);
endinterface

interface sbcl_out_if #(parameter int FB = sbcl_pkg::FracBits);
  logic valid;
  logic ready;
  logic [FB:0] limit_out_x;
  logic [FB:0] limit_out_y;
  logic signed [1:0] normal_x;
  logic signed [1:0] normal_y;
  logic hit;
  modport source (output valid, limit_out_x, limit_out_y, normal_x, normal_y, hit,
                  input ready);
  modport sink (input valid, limit_out_x, limit_out_y, normal_x, normal_y, hit,
                output ready);
endinterface

>>> hdl/sbcl_div.sv
// Pipelined restoring divider: quotient of (gap << FB) by den, one bit a stage.
// Depends on sbcl_pkg; advances only when en is high.
module sbcl_div #(
  parameter int NB = 16,
  parameter int QB = 33,
  parameter int TB = 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [QB-1:0] num,
  input  logic [NB-1:0] den,
  input  logic [TB-1:0] tag_in,
  output logic [QB-1:0] quo,
  output logic [TB-1:0] tag_out
);
  import sbcl_pkg::*;

  logic [NB:0]   rem [QB+1];
  logic [QB-1:0] qs  [QB+1];
  logic [QB-1:0] ns  [QB+1];
  logic [NB-1:0] ds  [QB+1];
  logic [TB-1:0] ts  [QB+1];

  assign rem[0] = '0;
  assign qs[0]  = '0;
  assign ns[0]  = num;
  assign ds[0]  = den;
  assign ts[0]  = tag_in;

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic [NB+1:0] sh;
    logic [NB+1:0] diff;
    assign sh   = {rem[i], ns[i][QB-1-i]};
    assign diff = sh - {2'b00, ds[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (!diff[NB+1]) begin
          rem[i+1] <= diff[NB:0];
          qs[i+1]  <= {qs[i][QB-2:0], 1'b1};
        end else begin
          rem[i+1] <= sh[NB:0];
          qs[i+1]  <= {qs[i][QB-2:0], 1'b0};
        end
        ns[i+1] <= ns[i];
        ds[i+1] <= ds[i];
        ts[i+1] <= ts[i];
      end
    end
  end

  assign quo     = qs[QB];
  assign tag_out = ts[QB];
endmodule

>>> hdl/swept_box_collision_limit.sv
// Top level of the swept box collision limit block.
// Depends on sbcl_pkg, sbcl_if and sbcl_div.
// One word is accepted every cycle while the pipeline is not stalled. A word
// passes through stage 1, stage 2, the bit-per-stage dividers on each axis
// and the final stage. The whole pipeline stalls together when the output
// register is full and not taken, and no word is taken while reset is high.
module swept_box_collision_limit #(
  parameter int COORD_BITS = sbcl_pkg::CoordBits,
  parameter int FRAC_BITS  = sbcl_pkg::FracBits
) (
  input logic clk,
  input logic rst,
  sbcl_in_if.sink    in_ch,
  sbcl_out_if.source out_ch
);
  import sbcl_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int FB = FRAC_BITS;
  localparam int WB = CB + 2;
  localparam int QB = CB + 1 + FB;
  localparam int LAT = QB + 2;
  localparam int TB = FB + 1 + 2;

  logic adv;
  logic [LAT:0] vld;

  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv && !rst;

  // Stage 1: spans, leading edges and overlap tests.
  logic signed [WB-1:0] ax, ay, bx, by, aw, ah, bw, bh, mx, my;
  assign ax = WB'(in_ch.a_x);
  assign ay = WB'(in_ch.a_y);
  assign bx = WB'(in_ch.b_x);
  assign by = WB'(in_ch.b_y);
  assign aw = WB'({1'b0, in_ch.a_width});
  assign ah = WB'({1'b0, in_ch.a_height});
  assign bw = WB'({1'b0, in_ch.b_width});
  assign bh = WB'({1'b0, in_ch.b_height});
  assign mx = WB'(in_ch.move_x);
  assign my = WB'(in_ch.move_y);

  logic ovx, ovy;
  logic signed [WB-1:0] ax1, ay1, bx1, by1;
  assign ax1 = ax + aw;
  assign ay1 = ay + ah;
  assign bx1 = bx + bw;
  assign by1 = by + bh;
  assign ovx = (ax <= bx1 && ax >= bx) || (ax1 <= bx1 && ax1 >= bx);
  assign ovy = (ay <= by1 && ay >= by) || (ay1 <= by1 && ay1 >= by);

  logic signed [WB-1:0] s1_ax, s1_ay, s1_bx, s1_by, s1_ax1, s1_ay1, s1_bx1, s1_by1;
  logic signed [WB-1:0] s1_mx, s1_my;
  logic s1_ovx, s1_ovy;
  logic [FB:0] s1_lx, s1_ly;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ax <= ax; s1_ay <= ay; s1_bx <= bx; s1_by <= by;
      s1_ax1 <= ax1; s1_ay1 <= ay1; s1_bx1 <= bx1; s1_by1 <= by1;
      s1_mx <= mx; s1_my <= my; s1_ovx <= ovx; s1_ovy <= ovy;
      s1_lx <= in_ch.limit_in_x; s1_ly <= in_ch.limit_in_y;
    end
  end

  // Stage 2: hit decision, gap and divisor per axis.
  typedef struct packed {
    logic          hit;
    logic          pos;
    logic [CB:0]   gap;
    logic [CB:0]   den;
  } axis_t;

  function automatic axis_t axis_eval(logic signed [WB-1:0] ap, logic signed [WB-1:0] ae,
                                      logic signed [WB-1:0] bp, logic signed [WB-1:0] be,
                                      logic signed [WB-1:0] mv, logic ov);
    axis_t r;
    logic signed [WB-1:0] g;
    logic signed [WB-1:0] d;
    r = '0;
    g = '0;
    d = '0;
    if (!mv[WB-1] && mv != '0) begin
      r.hit = (ae + mv >= bp) && (ae <= bp) && ov;
      r.pos = 1'b1;
      g = bp - ae;
      d = mv;
    end else if (mv[WB-1]) begin
      r.hit = (ap + mv <= be) && (ap >= be) && ov;
      g = ap - be;
      d = -mv;
    end
    r.gap = g[CB:0];
    r.den = d[CB:0];
    return r;
  endfunction

  axis_t s2_x, s2_y;
  logic [FB:0] s2_lx, s2_ly;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_x <= axis_eval(s1_ax, s1_ax1, s1_bx, s1_bx1, s1_mx, s1_ovy);
      s2_y <= axis_eval(s1_ay, s1_ay1, s1_by, s1_by1, s1_my, s1_ovx);
      s2_lx <= s1_lx;
      s2_ly <= s1_ly;
    end
  end

  // Dividers: the divisor is forced to one when there is no hit.
  logic [QB-1:0] numx, numy, qx, qy;
  logic [CB:0] denx, deny;
  logic [TB-1:0] tgx, tgy, tox, toy;
  assign numx = s2_x.hit ? {s2_x.gap, FB'(0)} : '0;
  assign numy = s2_y.hit ? {s2_y.gap, FB'(0)} : '0;
  assign denx = s2_x.hit ? s2_x.den : (CB+1)'(1);
  assign deny = s2_y.hit ? s2_y.den : (CB+1)'(1);
  assign tgx = {s2_lx, s2_x.hit, s2_x.pos};
  assign tgy = {s2_ly, s2_y.hit, s2_y.pos};

  sbcl_div #(.NB(CB+1), .QB(QB), .TB(TB)) u_divx (
    .clk(clk), .en(adv), .num(numx), .den(denx), .tag_in(tgx), .quo(qx), .tag_out(tox));
  sbcl_div #(.NB(CB+1), .QB(QB), .TB(TB)) u_divy (
    .clk(clk), .en(adv), .num(numy), .den(deny), .tag_in(tgy), .quo(qy), .tag_out(toy));

  // Final stage: minimum, clamp and normals.
  function automatic logic [FB:0] lim_sel(logic [QB-1:0] q, logic [TB-1:0] t);
    logic [QB-1:0] l;
    logic [QB-1:0] one;
    l = QB'(t[TB-1:2]);
    one = QB'(1) << FB;
    if (t[1] && q < l) l = q;
    if (l > one) l = one;
    return l[FB:0];
  endfunction

  function automatic logic signed [1:0] norm_sel(logic [TB-1:0] t);
    if (!t[1]) return NormNone;
    return t[0] ? NormPos : NormNeg;
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch.limit_out_x <= lim_sel(qx, tox);
      out_ch.limit_out_y <= lim_sel(qy, toy);
      out_ch.normal_x    <= norm_sel(tox);
      out_ch.normal_y    <= norm_sel(toy);
      out_ch.hit         <= tox[1] || toy[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-1:0], in_ch.valid};
    end
  end
  assign out_ch.valid = vld[LAT];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.limit_out_x))
    else $error("result word changed while stalled");
  a_hit: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.hit == (out_ch.normal_x != NormNone || out_ch.normal_y != NormNone))
    else $error("hit flag disagrees with normals");
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.limit_out_x <= ((FB+1)'(1) << FB)
                  && out_ch.limit_out_y <= ((FB+1)'(1) << FB))
    else $error("limit above one");
endmodule
